@@ sv/mbpe_pkg.sv @@
// Shared types and constants of the monochrome bitmap pixel expander.
package mbpe_pkg;

   localparam int MBPE_MAX_ROW_BYTES = 8;
   localparam int MBPE_MAX_ROWS      = 64;

   localparam int COORD_W = 9;
   localparam int BYTE_W  = 8;

   // reset values of the configuration registers
   localparam logic [7:0] X_LEFT_RST     = 8'd0;
   localparam logic [7:0] Y_TOP_RST      = 8'd0;
   localparam logic [3:0] ROW_BYTES_RST  = 4'd2;
   localparam logic [6:0] ROW_COUNT_RST  = 7'd16;
   localparam logic [7:0] GLYPH_CODE_RST = 8'd0;
   localparam logic [7:0] COLOR_CODE_RST = 8'd0;

   typedef struct packed {
      logic [7:0] x_left;
      logic [7:0] y_top;
      logic [3:0] row_bytes;
      logic [6:0] row_count;
      logic [7:0] glyph_code;
      logic [7:0] color_code;
   } cfg_type;

   // one queued byte: its pixel bits and the screen position of its first pixel
   typedef struct packed {
      logic [BYTE_W-1:0]  bits;
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
   } entry_type;

endpackage

@@ sv/mbpe_csr.sv @@
// Configuration register file with APB-style access.
module mbpe_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output mbpe_pkg::cfg_type    cfg
);
   import mbpe_pkg::*;

   typedef enum logic [2:0] {
      REG_X_LEFT     = 3'd0,
      REG_Y_TOP      = 3'd1,
      REG_ROW_BYTES  = 3'd2,
      REG_ROW_COUNT  = 3'd3,
      REG_GLYPH_CODE = 3'd4,
      REG_COLOR_CODE = 3'd5
   } reg_index_type;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_X_LEFT:     cfg_in.x_left     = csr_pwdata[7:0];
            REG_Y_TOP:      cfg_in.y_top      = csr_pwdata[7:0];
            REG_ROW_BYTES:  cfg_in.row_bytes  = csr_pwdata[3:0];
            REG_ROW_COUNT:  cfg_in.row_count  = csr_pwdata[6:0];
            REG_GLYPH_CODE: cfg_in.glyph_code = csr_pwdata[7:0];
            REG_COLOR_CODE: cfg_in.color_code = csr_pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_X_LEFT:     csr_prdata = 32'(cfg_ff.x_left);
         REG_Y_TOP:      csr_prdata = 32'(cfg_ff.y_top);
         REG_ROW_BYTES:  csr_prdata = 32'(cfg_ff.row_bytes);
         REG_ROW_COUNT:  csr_prdata = 32'(cfg_ff.row_count);
         REG_GLYPH_CODE: csr_prdata = 32'(cfg_ff.glyph_code);
         REG_COLOR_CODE: csr_prdata = 32'(cfg_ff.color_code);
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_left     <= X_LEFT_RST;
         cfg_ff.y_top      <= Y_TOP_RST;
         cfg_ff.row_bytes  <= ROW_BYTES_RST;
         cfg_ff.row_count  <= ROW_COUNT_RST;
         cfg_ff.glyph_code <= GLYPH_CODE_RST;
         cfg_ff.color_code <= COLOR_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/mbpe_front.sv @@
// Front end: accepts bytes, tracks column/row position, queues nonzero bytes.
module mbpe_front #(
   parameter int MAX_ROW_BYTES = mbpe_pkg::MBPE_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = mbpe_pkg::MBPE_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbpe_pkg::cfg_type    cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   output logic                 q_push,
   output mbpe_pkg::entry_type  q_entry,
   input  logic                 q_full
);
   import mbpe_pkg::*;

   localparam int CW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int NBW = $clog2(MAX_ROW_BYTES + 1);
   localparam int NRW = $clog2(MAX_ROWS + 1);

   logic [CW-1:0]  col_ff, col_in, col_cur;
   logic [RW-1:0]  row_ff, row_in, row_cur;
   logic [CW:0]    col_next;
   logic [RW:0]    row_next;
   logic [NBW-1:0] nb;
   logic [NRW-1:0] nr;
   logic           accept;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;

   // effective limits: zero counts as one, oversize saturates
   always_comb begin
      if (cfg.row_bytes == 4'd0)                     nb = NBW'(1);
      else if (32'(cfg.row_bytes) > MAX_ROW_BYTES)   nb = NBW'(MAX_ROW_BYTES);
      else                                           nb = NBW'(cfg.row_bytes);
      if (cfg.row_count == 7'd0)                     nr = NRW'(1);
      else if (32'(cfg.row_count) > MAX_ROWS)        nr = NRW'(MAX_ROWS);
      else                                           nr = NRW'(cfg.row_count);
   end

   assign col_cur  = req_tuser ? '0 : col_ff;
   assign row_cur  = req_tuser ? '0 : row_ff;
   assign col_next = (CW+1)'(col_cur) + (CW+1)'(1);
   assign row_next = (RW+1)'(row_cur) + (RW+1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= (CW+1)'(nb)) begin
            col_in = '0;
            row_in = (row_next >= (RW+1)'(nr)) ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   assign q_push         = accept & (req_tdata != 8'd0);
   assign q_entry.bits   = req_tdata;
   // double-width cells: 16 screen columns per bitmap byte
   assign q_entry.base_x = COORD_W'(cfg.x_left) + (COORD_W'(col_cur) << 4);
   assign q_entry.base_y = COORD_W'(cfg.y_top) + COORD_W'(row_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ sv/mbpe_queue.sv @@
// Short FIFO of classified bytes between front and back.
module mbpe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbpe_pkg::entry_type  push_entry,
   input  logic                 pop,
   output mbpe_pkg::entry_type  head,
   output logic                 full,
   output logic                 empty
);
   import mbpe_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   entry_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + (PW+1)'(1);
      else if (!push && pop) cnt_in = cnt_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ sv/mbpe_back.sv @@
// Back end: scans the head byte MSB first, one pixel write per cycle while the output register is free.
module mbpe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mbpe_pkg::cfg_type    cfg,
   input  mbpe_pkg::entry_type  q_head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic                 rsp_tlast
);
   import mbpe_pkg::*;

   logic [BYTE_W-1:0]  done_ff, done_in;
   logic [BYTE_W-1:0]  rem, pick, rem_after;
   logic [2:0]         pos;
   logic               found, out_free, fire, last;
   logic               vld_ff, vld_in;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [7:0]         glyph_ff, color_ff;
   logic               last_ff;

   // bits of the head byte not yet emitted
   assign rem = q_head.bits & ~done_ff;

   always_comb begin
      pos   = 3'd0;
      found = 1'b0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (!found && rem[BYTE_W-1-i]) begin
            pos   = 3'(i);
            found = 1'b1;
         end
      end
   end

   assign pick      = 8'h80 >> pos;
   assign rem_after = rem & ~pick;
   assign last      = (rem_after == '0);
   assign out_free  = ~vld_ff | rsp_tready;
   assign fire      = ~q_empty & out_free;
   assign q_pop     = fire & last;

   always_comb begin
      done_in = done_ff;
      if (fire) done_in = last ? '0 : (done_ff | pick);
      vld_in = vld_ff;
      if (fire)            vld_in = 1'b1;
      else if (rsp_tready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         x_ff     <= q_head.base_x + COORD_W'({pos, 1'b0});
         y_ff     <= q_head.base_y;
         glyph_ff <= cfg.glyph_code;
         color_ff <= cfg.color_code;
         last_ff  <= last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {6'd0, color_ff, glyph_ff, y_ff, x_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ sv/mono_bitmap_pixel_expander_top.sv @@
// Top level of the monochrome bitmap pixel expander.
// Expands a 1-bit-per-pixel glyph bitmap, fed one byte per item in row-major
// order, into pixel writes: one result item per set bit, leftmost (bit 7)
// first, with x = x_left + 2 * (8 * column + bit), y = y_top + row, and the
// configured glyph and color codes; tlast marks the last pixel of a byte and a
// byte with no set bits produces nothing. Column and row counters advance per
// byte and wrap at the configured (clamped) row_bytes / row_count; tuser set
// on an input item restarts them at row 0, column 0. The result side emits
// one pixel per cycle while the receiver is ready, so a byte with k set
// bits gives k pixels (1 to 8) and an empty byte none; the input takes one
// item per cycle while the 4-entry byte queue between the front end and the
// pixel scanner has room. Bytes are registered in the queue, pixels in the
// output register. Configuration registers should only be changed while idle.
module mono_bitmap_pixel_expander_top #(
   parameter int MAX_ROW_BYTES = mbpe_pkg::MBPE_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = mbpe_pkg::MBPE_MAX_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] bitmap_byte
   input  logic        req_tuser,   // [0] start_glyph
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [8:0] pix_x, [17:9] pix_y, [25:18] pix_glyph,
                                    // [33:26] pix_color, [39:34] zero
   output logic        rsp_tlast,   // last_of_byte
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mbpe_pkg::*;

   cfg_type   cfg;
   entry_type q_entry, q_head;
   logic      q_push, q_pop, q_full, q_empty;

   mbpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // position tracking and classification
   mbpe_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_ROWS      (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_entry    (q_entry),
      .q_full     (q_full)
   );

   mbpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // per-bit scan into the output register
   mbpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // only bytes with set bits enter the queue, and only when it has room
   a_push_ok: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_entry.bits != 8'd0) && !q_full)
      else $error("queue push of empty byte or into full queue");

   // retiring a byte always leaves its final pixel, flagged, in the output register
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty ##1 (rsp_tvalid && rsp_tlast))
      else $error("byte retired without a flagged final pixel");

   // a start byte is placed at the bitmap origin
   a_start_origin: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser && req_tdata != 8'd0) |->
         (q_push && q_entry.base_x == COORD_W'(cfg.x_left)
                 && q_entry.base_y == COORD_W'(cfg.y_top)))
      else $error("start byte not placed at origin");

endmodule

@@ sim/mbpe_checker.sv @@
// Register map and scoreboard of the bitmap pixel expander testbench.
package mbpe_tb_pkg;

   // register index; byte address is index * 4
   typedef enum logic [2:0] {
      REG_X_LEFT,
      REG_Y_TOP,
      REG_ROW_BYTES,
      REG_ROW_COUNT,
      REG_GLYPH_CODE,
      REG_COLOR_CODE
   } reg_index_type;

endpackage

module mbpe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);
   import mbpe_pkg::*;
   import mbpe_tb_pkg::*;

   typedef struct {
      logic [8:0] x;
      logic [8:0] y;
      logic [7:0] glyph;
      logic [7:0] color;
      logic       last;
   } pixel_type;

   pixel_type  expected_pixels[$];
   cfg_type    regs;
   logic [2:0] column;
   logic [5:0] row;
   int         errors = 0;

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Pixels of one bitmap byte at the current position, then the counter step.
   function automatic void place_byte(input logic [7:0] bits, input logic start);
      int        nb;
      int        nr;
      int        col;
      int        rw;
      int        last_pos;
      pixel_type p;

      nb = (regs.row_bytes == 0) ? 1 :
           (regs.row_bytes > MBPE_MAX_ROW_BYTES) ? MBPE_MAX_ROW_BYTES : int'(regs.row_bytes);
      nr = (regs.row_count == 0) ? 1 :
           (regs.row_count > MBPE_MAX_ROWS) ? MBPE_MAX_ROWS : int'(regs.row_count);
      col = start ? 0 : int'(column);
      rw  = start ? 0 : int'(row);

      last_pos = -1;
      for (int pos = 0; pos < 8; pos++)
         if (bits[7-pos]) last_pos = pos;

      for (int pos = 0; pos < 8; pos++) begin
         if (bits[7-pos]) begin
            p.x     = 9'(int'(regs.x_left) + (col * 8 + pos) * 2);
            p.y     = 9'(int'(regs.y_top) + rw);
            p.glyph = regs.glyph_code;
            p.color = regs.color_code;
            p.last  = (pos == last_pos);
            expected_pixels.insert(expected_pixels.size(), p);
         end
      end

      col++;
      if (col >= nb) begin
         col = 0;
         rw++;
         if (rw >= nr) rw = 0;
      end
      column = 3'(col);
      row    = 6'(rw);
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         regs = '{x_left: X_LEFT_RST, y_top: Y_TOP_RST, row_bytes: ROW_BYTES_RST,
                  row_count: ROW_COUNT_RST, glyph_code: GLYPH_CODE_RST,
                  color_code: COLOR_CODE_RST};
         column = '0;
         row    = '0;
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_X_LEFT:     regs.x_left     = csr_pwdata[7:0];
               REG_Y_TOP:      regs.y_top      = csr_pwdata[7:0];
               REG_ROW_BYTES:  regs.row_bytes  = csr_pwdata[3:0];
               REG_ROW_COUNT:  regs.row_count  = csr_pwdata[6:0];
               REG_GLYPH_CODE: regs.glyph_code = csr_pwdata[7:0];
               REG_COLOR_CODE: regs.color_code = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            place_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report($sformatf("unexpected pixel x=%0d y=%0d",
                                rsp_tdata[8:0], rsp_tdata[17:9]));
            end else begin
               want = expected_pixels.pop_front();
               check_field("pix_x",        rsp_tdata[8:0],   want.x);
               check_field("pix_y",        rsp_tdata[17:9],  want.y);
               check_field("pix_glyph",    rsp_tdata[25:18], want.glyph);
               check_field("pix_color",    rsp_tdata[33:26], want.color);
               check_field("tdata pad",    rsp_tdata[39:34], 0);
               check_field("last_of_byte", rsp_tlast,        want.last);
            end
         end
      end
      pending_count <= expected_pixels.size();
      fail_count    <= errors;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the bitmap pixel expander testbench: stimulus, flow control and verdict.
module testbench;
   import mbpe_pkg::*;
   import mbpe_tb_pkg::*;

   // all block inputs start at known values
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = '0;    // [7:0] bitmap_byte
   logic        req_tuser   = 1'b0;  // [0] start_glyph
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;          // [8:0] x, [17:9] y, [25:18] glyph, [33:26] color
   logic        rsp_tlast;          // last_of_byte
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;

   // sender bookkeeping
   int burst_left = 0;
   int items_sent = 0;
   // receiver stall pattern
   int ready_run  = 0;

   always #5 clock = ~clock;

   mono_bitmap_pixel_expander_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Scoreboard: snoops all three ports, predicts pixels, compares.
   mbpe_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Receiver: runs of ready and stall. Long ready runs give stretches with
   // no backpressure; short mixed runs put stalls between the pixels of a byte.
   always @(posedge clock) begin
      int pick;
      if (ready_run == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            rsp_tready <= 1'b1;
            ready_run = $urandom_range(20, 80);
         end else if (pick < 6) begin
            rsp_tready <= 1'b1;
            ready_run = $urandom_range(1, 4);
         end else begin
            rsp_tready <= 1'b0;
            ready_run = $urandom_range(1, 6);
         end
      end else begin
         ready_run--;
      end
   end

   // One bitmap byte. Valid stays high across a burst; a random gap
   // (sometimes none) follows each burst.
   task automatic send_byte(input logic [7:0] bits, input logic start);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every predicted pixel is out, plus some
   // idle slack before touching registers.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Writes all registers back to back: setup then access cycle each,
   // psel held high across the sequence.
   task automatic load_registers(input cfg_type c);
      reg_index_type idx;
      logic [31:0]   value;
      idx = idx.first();
      do begin
         case (idx)
            REG_X_LEFT:     value = 32'(c.x_left);
            REG_Y_TOP:      value = 32'(c.y_top);
            REG_ROW_BYTES:  value = 32'(c.row_bytes);
            REG_ROW_COUNT:  value = 32'(c.row_count);
            REG_GLYPH_CODE: value = 32'(c.glyph_code);
            default:        value = 32'(c.color_code);
         endcase
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {idx, 2'b00};
         csr_pwdata  <= value;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [7:0] edge_or_random8();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Settings for a random phase: extremes often, zero and oversized
   // geometry included; row counts mostly short so rows wrap within a glyph.
   function automatic cfg_type random_setting();
      cfg_type c;
      c.x_left     = edge_or_random8();
      c.y_top      = edge_or_random8();
      c.glyph_code = edge_or_random8();
      c.color_code = edge_or_random8();
      c.row_bytes  = 4'($urandom_range(0, 15));
      c.row_count  = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 8));
      return c;
   endfunction

   // Empty, full, single-pixel and random rows.
   function automatic logic [7:0] random_bits();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80 >> $urandom_range(0, 7);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      cfg_type setting;
      int      target;
      int      phase_items;
      int      sent_here;
      int      glyph_len;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset geometry: 2 bytes per row, 16 rows
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);   // empty byte still advances the column
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);

      // all registers at their largest effective values, widest coordinates
      wait_for_drain();
      setting = '{x_left: 8'hFF, y_top: 8'hFF, row_bytes: 4'd8, row_count: 7'd64,
                  glyph_code: 8'hFF, color_code: 8'hFF};
      load_registers(setting);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'hFF, 1'b0);   // column now 5

      // shrink the row mid-glyph: column past the new limit wraps next step
      wait_for_drain();
      setting.row_bytes = 4'd2;
      load_registers(setting);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h18, 1'b0);

      // zero geometry counts as one byte / one row
      wait_for_drain();
      setting = '{x_left: 8'h00, y_top: 8'h00, row_bytes: 4'd0, row_count: 7'd0,
                  glyph_code: 8'h5A, color_code: 8'hA5};
      load_registers(setting);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);

      // oversized geometry saturates
      wait_for_drain();
      setting.row_bytes = 4'd15;
      setting.row_count = 7'd127;
      load_registers(setting);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h3C, 1'b0);

      // single byte, single row
      wait_for_drain();
      setting.row_bytes = 4'd1;
      setting.row_count = 7'd1;
      load_registers(setting);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h0F, 1'b0);

      // --- random phases ---
      // Mostly whole or partial glyphs opened by a start byte; some loose
      // bytes with a random start flag as noise.
      target = 380;
      while (items_sent < target) begin
         wait_for_drain();
         load_registers(random_setting());
         phase_items = $urandom_range(25, 60);
         sent_here   = 0;
         while (sent_here < phase_items && items_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
               send_byte(random_bits(), 1'($urandom_range(0, 1)));
               sent_here++;
            end else begin
               glyph_len = $urandom_range(1, 24);
               send_byte(random_bits(), 1'b1);
               for (int k = 1; k < glyph_len; k++)
                  send_byte(random_bits(), 1'b0);
               sent_here += glyph_len;
            end
            // now and then hold off until the output side is empty
            if ($urandom_range(0, 29) == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
